### src/hrht_pkg.sv
`timescale 1ns / 1ps
package hrht_pkg;

	localparam int DEF_WS_HOLD_DEPTH = 16;
	localparam int DEF_OFFSET_WIDTH  = 32;

	localparam int KIND_W = 4;
	localparam int BYTE_W = 8;
	localparam int HLEN_W = 32;

	localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
	localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
	localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] CHAR_SP    = 8'h20;
	localparam logic [BYTE_W-1:0] CHAR_COLON = 8'h3A;
	localparam logic [BYTE_W-1:0] CHAR_UC_A  = 8'h41;
	localparam logic [BYTE_W-1:0] CHAR_UC_Z  = 8'h5A;
	localparam logic [BYTE_W-1:0] CASE_BIT   = 8'h20;

	// token kinds on the result channel
	typedef enum logic [KIND_W-1:0] {
		K_METHOD_BYTE  = 4'd0,
		K_METHOD_END   = 4'd1,
		K_URL_BYTE     = 4'd2,
		K_URL_END      = 4'd3,
		K_KEY_BYTE     = 4'd4,
		K_VALUE_BYTE   = 4'd5,
		K_FIELD_END    = 4'd6,
		K_FIELD_DROP   = 4'd7,
		K_HEADER_END   = 4'd8,
		K_BODY_BYTE    = 4'd9,
		K_REQ_ERROR    = 4'd10
	} kind_t;

	// parse position within the request
	typedef enum logic [3:0] {
		PH_METHOD     = 4'd0,
		PH_URL        = 4'd1,
		PH_REQ_REST   = 4'd2,
		PH_LINE_START = 4'd3,
		PH_KEY_LEAD   = 4'd4,
		PH_KEY        = 4'd5,
		PH_VAL_LEAD   = 4'd6,
		PH_VAL        = 4'd7,
		PH_BODY       = 4'd8,
		PH_ERROR      = 4'd9
	} phase_t;

	typedef enum logic [2:0] {
		CS_IDLE,
		CS_DECODE,
		CS_FREAD,
		CS_FEMIT,
		CS_EMIT1,
		CS_EMIT2
	} ctl_state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic decode;
		logic flush_start;
		logic emit_flush;
		logic emit_e1;
		logic emit_e2;
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic c_flush;
		logic c_e1;
		logic c_e2;
		logic q_e1;
		logic q_e2;
		logic flush_last;
		logic out_free;
	} ctl_stat_t;

endpackage

### src/http_request_header_tokenizer.sv
`timescale 1ns / 1ps
// channel | handshake           | payload
// --------+---------------------+---------------------------------------------------
// in      | in_valid, in_ready  | data_byte[7:0], start_message
// out     | out_valid, out_ready| kind[3:0], out_byte[7:0], header_length[31:0],
//         |                     | ws_overflow, last_of_run
//
// Steps: an item is accepted, then decoded, then places each result it causes,
// one after another; held whitespace that is flushed comes first, after a read
// of the hold store. The decode step and the single-read hold store set this.
// Reset: arst_n clears the parser to the request method phase, no CR or
// whitespace held, byte count zero. The hold store needs no clearing.
// Stalls: out_ready low holds the finished item in the output register; the
// next byte is still taken once the current one has placed its last result.
module http_request_header_tokenizer #(
	parameter int WS_HOLD_DEPTH = hrht_pkg::DEF_WS_HOLD_DEPTH,
	parameter int OFFSET_WIDTH  = hrht_pkg::DEF_OFFSET_WIDTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [hrht_pkg::BYTE_W-1:0] data_byte,
	input  logic                        start_message,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [hrht_pkg::KIND_W-1:0] kind,
	output logic [hrht_pkg::BYTE_W-1:0] out_byte,
	output logic [hrht_pkg::HLEN_W-1:0] header_length,
	output logic                        ws_overflow,
	output logic                        last_of_run
);

	// command and status between the sequencer and the datapath
	hrht_pkg::ctl_cmd_t  cmd;
	hrht_pkg::ctl_stat_t stat;

	// sequencer: accept, decode, then walk the flush and single tokens
	hrht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath: parser state, per-item plan, hold store, output register
	hrht_dpath #(
		.WS_HOLD_DEPTH (WS_HOLD_DEPTH),
		.OFFSET_WIDTH  (OFFSET_WIDTH)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.data_byte     (data_byte),
		.start_message (start_message),
		.cmd           (cmd),
		.stat          (stat),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.kind          (kind),
		.out_byte      (out_byte),
		.header_length (header_length),
		.ws_overflow   (ws_overflow),
		.last_of_run   (last_of_run)
	);

endmodule

### src/hrht_ram.sv
`timescale 1ns / 1ps
module hrht_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

### src/hrht_ctrl.sv
`timescale 1ns / 1ps
module hrht_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  hrht_pkg::ctl_stat_t stat,
	output hrht_pkg::ctl_cmd_t  cmd
);

	hrht_pkg::ctl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= hrht_pkg::CS_IDLE;
		else
			state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hrht_pkg::CS_IDLE: begin
				if (in_valid)
					state_d = hrht_pkg::CS_DECODE;
			end
			hrht_pkg::CS_DECODE: begin
				if (stat.c_flush)
					state_d = hrht_pkg::CS_FREAD;
				else if (stat.c_e1)
					state_d = hrht_pkg::CS_EMIT1;
				else if (stat.c_e2)
					state_d = hrht_pkg::CS_EMIT2;
				else
					state_d = hrht_pkg::CS_IDLE;
			end
			hrht_pkg::CS_FREAD: begin
				state_d = hrht_pkg::CS_FEMIT;
			end
			hrht_pkg::CS_FEMIT: begin
				if (stat.out_free && stat.flush_last) begin
					if (stat.q_e1)
						state_d = hrht_pkg::CS_EMIT1;
					else if (stat.q_e2)
						state_d = hrht_pkg::CS_EMIT2;
					else
						state_d = hrht_pkg::CS_IDLE;
				end
			end
			hrht_pkg::CS_EMIT1: begin
				if (stat.out_free)
					state_d = stat.q_e2 ? hrht_pkg::CS_EMIT2 : hrht_pkg::CS_IDLE;
			end
			hrht_pkg::CS_EMIT2: begin
				if (stat.out_free)
					state_d = hrht_pkg::CS_IDLE;
			end
			default: state_d = hrht_pkg::CS_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			hrht_pkg::CS_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			hrht_pkg::CS_DECODE: cmd.decode      = 1'b1;
			hrht_pkg::CS_FREAD:  cmd.flush_start = 1'b1;
			hrht_pkg::CS_FEMIT:  cmd.emit_flush  = stat.out_free;
			hrht_pkg::CS_EMIT1:  cmd.emit_e1     = stat.out_free;
			hrht_pkg::CS_EMIT2:  cmd.emit_e2     = stat.out_free;
			default: ;
		endcase
	end

endmodule

### src/hrht_dpath.sv
`timescale 1ns / 1ps
module hrht_dpath #(
	parameter int WS_HOLD_DEPTH = hrht_pkg::DEF_WS_HOLD_DEPTH,
	parameter int OFFSET_WIDTH  = hrht_pkg::DEF_OFFSET_WIDTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [hrht_pkg::BYTE_W-1:0]     data_byte,
	input  logic                            start_message,
	input  hrht_pkg::ctl_cmd_t              cmd,
	output hrht_pkg::ctl_stat_t             stat,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [hrht_pkg::KIND_W-1:0]     kind,
	output logic [hrht_pkg::BYTE_W-1:0]     out_byte,
	output logic [hrht_pkg::HLEN_W-1:0]     header_length,
	output logic                            ws_overflow,
	output logic                            last_of_run
);

	localparam int CW = $clog2(WS_HOLD_DEPTH + 1);
	localparam int AW = (WS_HOLD_DEPTH > 1) ? $clog2(WS_HOLD_DEPTH) : 1;
	localparam int OW = OFFSET_WIDTH;
	localparam int HW = (OW > hrht_pkg::HLEN_W) ? OW : hrht_pkg::HLEN_W;
	localparam logic [HW-1:0] HLEN_MAX = HW'({hrht_pkg::HLEN_W{1'b1}});

	function automatic logic [hrht_pkg::BYTE_W-1:0] to_lower(
		input logic [hrht_pkg::BYTE_W-1:0] b
	);
		logic [hrht_pkg::BYTE_W-1:0] r;
		r = b;
		if (b >= hrht_pkg::CHAR_UC_A && b <= hrht_pkg::CHAR_UC_Z)
			r = b | hrht_pkg::CASE_BIT;
		return r;
	endfunction

	// parser state
	logic [hrht_pkg::BYTE_W-1:0] byte_q;
	hrht_pkg::phase_t            ph_q;
	logic                        cr_q;
	logic                        skip_q;
	logic [CW-1:0]               cnt_q;
	logic [OW-1:0]               offset_q;

	// per-item plan
	logic [CW-1:0]               flush_n_q;
	logic [CW-1:0]               flush_idx_q;
	hrht_pkg::kind_t             f_kind_q;
	logic                        f_ovf_q;
	logic                        e1_q, e2_q;
	hrht_pkg::kind_t             e1_kind_q, e2_kind_q;
	logic [hrht_pkg::BYTE_W-1:0] e1_byte_q, e2_byte_q;
	logic [hrht_pkg::HLEN_W-1:0] e1_hl_q;
	logic                        hold_q, hold_tab_q;

	// output register
	logic                        out_valid_q;
	hrht_pkg::kind_t             kind_q;
	logic [hrht_pkg::BYTE_W-1:0] out_byte_q;
	logic [hrht_pkg::HLEN_W-1:0] hl_q;
	logic                        ovf_q;
	logic                        last_q;

	// decode results
	hrht_pkg::phase_t            n_ph, ph2;
	logic                        n_cr, n_skip;
	logic [CW-1:0]               n_cnt, cnt_eff;
	logic                        clr_cnt, flush_c, f_ovf_c, hold_c;
	hrht_pkg::kind_t             f_kind_c;
	logic                        e1_c, e2_c;
	hrht_pkg::kind_t             e1_kind_c, e2_kind_c;
	logic [hrht_pkg::BYTE_W-1:0] e1_byte_c, e2_byte_c;
	logic                        e1_hl_c;
	logic                        done;
	logic                        is_ws, is_cr, is_lf, is_colon, is_tab;
	logic [HW-1:0]               off_ext;
	logic [hrht_pkg::HLEN_W-1:0] hl_sat;

	// hold store
	logic                        ram_we, ram_re, ram_rdata, ram_wdata;
	logic [AW-1:0]               ram_waddr, ram_raddr;
	logic                        out_free;
	logic                        flush_last;

	assign is_tab   = (byte_q == hrht_pkg::CHAR_TAB);
	assign is_ws    = is_tab || (byte_q == hrht_pkg::CHAR_SP);
	assign is_cr    = (byte_q == hrht_pkg::CHAR_CR);
	assign is_lf    = (byte_q == hrht_pkg::CHAR_LF);
	assign is_colon = (byte_q == hrht_pkg::CHAR_COLON);

	assign off_ext = HW'(offset_q);
	assign hl_sat  = (off_ext > HLEN_MAX) ? {hrht_pkg::HLEN_W{1'b1}}
	                                      : off_ext[hrht_pkg::HLEN_W-1:0];

	// work out everything one byte causes: an optional whitespace flush,
	// then up to two single tokens, plus the next parser state
	always_comb begin
		n_ph      = ph_q;
		ph2       = ph_q;
		n_cr      = cr_q;
		n_skip    = skip_q;
		clr_cnt   = 1'b0;
		flush_c   = 1'b0;
		f_ovf_c   = 1'b0;
		f_kind_c  = hrht_pkg::K_KEY_BYTE;
		hold_c    = 1'b0;
		e1_c      = 1'b0;
		e1_kind_c = hrht_pkg::K_METHOD_BYTE;
		e1_byte_c = '0;
		e1_hl_c   = 1'b0;
		e2_c      = 1'b0;
		e2_kind_c = hrht_pkg::K_METHOD_BYTE;
		e2_byte_c = '0;
		done      = 1'b0;
		cnt_eff   = cnt_q;

		unique case (ph_q)
			hrht_pkg::PH_BODY: begin
				e1_c      = 1'b1;
				e1_kind_c = hrht_pkg::K_BODY_BYTE;
				e1_byte_c = byte_q;
			end
			hrht_pkg::PH_METHOD, hrht_pkg::PH_URL, hrht_pkg::PH_REQ_REST: begin
				if (cr_q) begin
					n_cr = 1'b0;
					if (is_lf) begin
						done = 1'b1;
						if (ph_q == hrht_pkg::PH_REQ_REST) begin
							n_ph = hrht_pkg::PH_LINE_START;
						end else begin
							e1_c      = 1'b1;
							e1_kind_c = hrht_pkg::K_REQ_ERROR;
							n_ph      = hrht_pkg::PH_ERROR;
						end
					end else if (ph_q != hrht_pkg::PH_REQ_REST) begin
						e1_c      = 1'b1;
						e1_kind_c = (ph_q == hrht_pkg::PH_METHOD) ? hrht_pkg::K_METHOD_BYTE
						                                          : hrht_pkg::K_URL_BYTE;
						e1_byte_c = hrht_pkg::CHAR_CR;
					end
				end
				if (!done) begin
					if (is_cr) begin
						n_cr = 1'b1;
					end else if (byte_q == hrht_pkg::CHAR_SP) begin
						if (ph_q == hrht_pkg::PH_METHOD) begin
							e2_c      = 1'b1;
							e2_kind_c = hrht_pkg::K_METHOD_END;
							n_ph      = hrht_pkg::PH_URL;
						end else if (ph_q == hrht_pkg::PH_URL) begin
							e2_c      = 1'b1;
							e2_kind_c = hrht_pkg::K_URL_END;
							n_ph      = hrht_pkg::PH_REQ_REST;
						end
					end else if (ph_q != hrht_pkg::PH_REQ_REST) begin
						e2_c      = 1'b1;
						e2_kind_c = (ph_q == hrht_pkg::PH_METHOD) ? hrht_pkg::K_METHOD_BYTE
						                                          : hrht_pkg::K_URL_BYTE;
						e2_byte_c = byte_q;
					end
				end
			end
			hrht_pkg::PH_LINE_START, hrht_pkg::PH_KEY_LEAD, hrht_pkg::PH_KEY,
			hrht_pkg::PH_VAL_LEAD, hrht_pkg::PH_VAL: begin
				if (cr_q) begin
					n_cr = 1'b0;
					if (is_lf) begin
						done    = 1'b1;
						clr_cnt = 1'b1;
						n_skip  = 1'b0;
						e1_c    = 1'b1;
						if (ph_q == hrht_pkg::PH_LINE_START) begin
							e1_kind_c = hrht_pkg::K_HEADER_END;
							e1_hl_c   = 1'b1;
							n_ph      = hrht_pkg::PH_BODY;
						end else begin
							e1_kind_c = (skip_q || ph_q == hrht_pkg::PH_KEY_LEAD ||
							             ph_q == hrht_pkg::PH_KEY) ? hrht_pkg::K_FIELD_DROP
							                                       : hrht_pkg::K_FIELD_END;
							n_ph      = hrht_pkg::PH_LINE_START;
						end
					end else if (!skip_q) begin
						// a lone CR is token content
						e1_c      = 1'b1;
						e1_byte_c = hrht_pkg::CHAR_CR;
						if (ph_q == hrht_pkg::PH_LINE_START ||
						    ph_q == hrht_pkg::PH_KEY_LEAD) begin
							ph2       = hrht_pkg::PH_KEY;
							e1_kind_c = hrht_pkg::K_KEY_BYTE;
						end else if (ph_q == hrht_pkg::PH_KEY) begin
							flush_c   = (cnt_q != '0);
							clr_cnt   = 1'b1;
							cnt_eff   = '0;
							e1_kind_c = hrht_pkg::K_KEY_BYTE;
						end else if (ph_q == hrht_pkg::PH_VAL_LEAD) begin
							ph2       = hrht_pkg::PH_VAL;
							e1_kind_c = hrht_pkg::K_VALUE_BYTE;
						end else begin
							flush_c   = (cnt_q != '0);
							clr_cnt   = 1'b1;
							cnt_eff   = '0;
							f_kind_c  = hrht_pkg::K_VALUE_BYTE;
							e1_kind_c = hrht_pkg::K_VALUE_BYTE;
						end
					end
				end
				if (!done) begin
					n_ph = ph2;
					if (is_cr) begin
						n_cr = 1'b1;
					end else if (!skip_q) begin
						unique case (ph2)
							hrht_pkg::PH_LINE_START, hrht_pkg::PH_KEY_LEAD: begin
								if (is_ws) begin
									n_ph = hrht_pkg::PH_KEY_LEAD;
								end else if (is_colon) begin
									n_skip = 1'b1;
									n_ph   = hrht_pkg::PH_KEY_LEAD;
								end else begin
									n_ph      = hrht_pkg::PH_KEY;
									e2_c      = 1'b1;
									e2_kind_c = hrht_pkg::K_KEY_BYTE;
									e2_byte_c = to_lower(byte_q);
								end
							end
							hrht_pkg::PH_KEY, hrht_pkg::PH_VAL: begin
								if (ph2 == hrht_pkg::PH_VAL)
									f_kind_c = hrht_pkg::K_VALUE_BYTE;
								if (is_ws) begin
									hold_c = 1'b1;
									if (cnt_eff == CW'(WS_HOLD_DEPTH)) begin
										flush_c = 1'b1;
										f_ovf_c = 1'b1;
									end
								end else if (is_colon && ph2 == hrht_pkg::PH_KEY) begin
									clr_cnt = 1'b1;
									n_ph    = hrht_pkg::PH_VAL_LEAD;
								end else begin
									if (cnt_eff != '0)
										flush_c = 1'b1;
									clr_cnt = 1'b1;
									e2_c    = 1'b1;
									if (ph2 == hrht_pkg::PH_KEY) begin
										e2_kind_c = hrht_pkg::K_KEY_BYTE;
										e2_byte_c = to_lower(byte_q);
									end else begin
										e2_kind_c = hrht_pkg::K_VALUE_BYTE;
										e2_byte_c = byte_q;
									end
								end
							end
							hrht_pkg::PH_VAL_LEAD: begin
								if (!is_ws) begin
									n_ph      = hrht_pkg::PH_VAL;
									e2_c      = 1'b1;
									e2_kind_c = hrht_pkg::K_VALUE_BYTE;
									e2_byte_c = byte_q;
								end
							end
							default: ;
						endcase
					end
				end
			end
			default: ;
		endcase

		if (hold_c)
			n_cnt = (flush_c || clr_cnt) ? CW'(1) : cnt_q + CW'(1);
		else
			n_cnt = (flush_c || clr_cnt) ? '0 : cnt_q;
	end

	assign out_free   = !out_valid_q || out_ready;
	assign flush_last = (flush_idx_q == flush_n_q - CW'(1));

	always_comb begin
		stat            = '0;
		stat.c_flush    = flush_c;
		stat.c_e1       = e1_c;
		stat.c_e2       = e2_c;
		stat.q_e1       = e1_q;
		stat.q_e2       = e2_q;
		stat.flush_last = flush_last;
		stat.out_free   = out_free;
	end

	// parser state and plan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q     <= hrht_pkg::PH_METHOD;
			cr_q     <= 1'b0;
			skip_q   <= 1'b0;
			cnt_q    <= '0;
			offset_q <= '0;
			e1_q     <= 1'b0;
			e2_q     <= 1'b0;
			hold_q   <= 1'b0;
		end else if (cmd.load) begin
			if (start_message) begin
				ph_q     <= hrht_pkg::PH_METHOD;
				cr_q     <= 1'b0;
				skip_q   <= 1'b0;
				cnt_q    <= '0;
				offset_q <= OW'(1);
			end else if (!(&offset_q)) begin
				offset_q <= offset_q + OW'(1);
			end
		end else if (cmd.decode) begin
			ph_q   <= n_ph;
			cr_q   <= n_cr;
			skip_q <= n_skip;
			cnt_q  <= n_cnt;
			e1_q   <= e1_c;
			e2_q   <= e2_c;
			hold_q <= hold_c && flush_c;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			byte_q <= data_byte;
		if (cmd.decode) begin
			flush_n_q  <= cnt_q;
			f_kind_q   <= f_kind_c;
			f_ovf_q    <= f_ovf_c;
			e1_kind_q  <= e1_kind_c;
			e1_byte_q  <= e1_byte_c;
			e1_hl_q    <= e1_hl_c ? hl_sat : '0;
			e2_kind_q  <= e2_kind_c;
			e2_byte_q  <= e2_byte_c;
			hold_tab_q <= is_tab;
		end
		if (cmd.flush_start)
			flush_idx_q <= '0;
		else if (cmd.emit_flush && !flush_last)
			flush_idx_q <= flush_idx_q + CW'(1);
	end

	// hold store: read ahead one entry while the current one is emitted;
	// a hold that follows a flush writes entry zero once all reads are done
	always_comb begin
		ram_re    = cmd.flush_start || (cmd.emit_flush && !flush_last);
		ram_raddr = cmd.flush_start ? '0 : AW'(flush_idx_q + CW'(1));
		ram_we    = (cmd.decode && hold_c && !flush_c) ||
		            (cmd.emit_flush && flush_last && hold_q);
		ram_waddr = cmd.decode ? AW'(cnt_q) : '0;
		ram_wdata = cmd.decode ? is_tab : hold_tab_q;
	end

	hrht_ram #(
		.WIDTH (1),
		.DEPTH (WS_HOLD_DEPTH),
		.AW    (AW)
	) u_hold (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit_flush || cmd.emit_e1 || cmd.emit_e2)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_flush) begin
			kind_q     <= f_kind_q;
			out_byte_q <= ram_rdata ? hrht_pkg::CHAR_TAB : hrht_pkg::CHAR_SP;
			hl_q       <= '0;
			ovf_q      <= f_ovf_q;
			last_q     <= flush_last && !e1_q && !e2_q;
		end else if (cmd.emit_e1) begin
			kind_q     <= e1_kind_q;
			out_byte_q <= e1_byte_q;
			hl_q       <= e1_hl_q;
			ovf_q      <= 1'b0;
			last_q     <= !e2_q;
		end else if (cmd.emit_e2) begin
			kind_q     <= e2_kind_q;
			out_byte_q <= e2_byte_q;
			hl_q       <= '0;
			ovf_q      <= 1'b0;
			last_q     <= 1'b1;
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = kind_q;
	assign out_byte      = out_byte_q;
	assign header_length = hl_q;
	assign ws_overflow   = ovf_q;
	assign last_of_run   = last_q;

endmodule
